/* rtl/vid_pkg.sv */
// Shared constants and types for the vertex index deduplication table.
`default_nettype none

package vid_pkg;

    // Width of each incoming index field
    localparam int unsigned FIELD_W     = 20;
    // Width of the vertex id on the result port
    localparam int unsigned VERTEX_ID_W = 8;

    // Default table size and stored index width
    localparam int unsigned DEFAULT_TABLE_DEPTH = 256;
    localparam int unsigned DEFAULT_INDEX_BITS  = 20;

    // Status that travels with a request along the cell chain
    typedef struct packed {
        logic valid;   // slot holds a request
        logic found;   // request matched or was inserted upstream
        logic is_new;  // request was inserted upstream
    } vid_flags_t;

endpackage

`default_nettype wire

/* rtl/vid_cell.sv */
// One table cell: holds one stored triple and one pipeline slot of the request chain.
`default_nettype none

module vid_cell
    import vid_pkg::*;
#(
    parameter int unsigned INDEX_BITS = DEFAULT_INDEX_BITS,
    parameter int unsigned ID_W       = 8,
    parameter int unsigned SLOT       = 0
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    advance,
    input  vid_flags_t              flags_in,
    input  logic [3*INDEX_BITS-1:0] key_in,
    input  logic [ID_W-1:0]         id_in,
    output vid_flags_t              flags_out,
    output logic [3*INDEX_BITS-1:0] key_out,
    output logic [ID_W-1:0]         id_out
);

    localparam int unsigned KEY_W = 3 * INDEX_BITS;

    logic [KEY_W-1:0] entry_key_reg;
    logic             entry_valid_reg;
    logic             entry_valid_next;
    vid_flags_t       flags_reg;
    vid_flags_t       flags_next;
    logic [KEY_W-1:0] key_reg;
    logic [ID_W-1:0]  id_reg;
    logic [ID_W-1:0]  id_next;
    logic             hit;
    logic             ins;

    // Compare the passing request against the stored triple
    assign hit = flags_in.valid && !flags_in.found && entry_valid_reg
                 && (entry_key_reg == key_in);
    // Claim this cell when it is the first empty one the request meets
    assign ins = flags_in.valid && !flags_in.found && !entry_valid_reg;

    // Work out what this cell hands to its neighbour
    always_comb
    begin
        flags_next.valid  = flags_in.valid;
        flags_next.found  = flags_in.found | hit | ins;
        flags_next.is_new = flags_in.is_new | ins;
        id_next           = (hit || ins) ? ID_W'(SLOT) : id_in;
        entry_valid_next  = entry_valid_reg | ins;
    end

    // Advance control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg       <= '0;
            entry_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            flags_reg       <= flags_next;
            entry_valid_reg <= entry_valid_next;
        end
    end

    // Advance payload and store the key on insertion
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            key_reg <= key_in;
            id_reg  <= id_next;
            if (ins)
            begin
                entry_key_reg <= key_in;
            end
        end
    end

    assign flags_out = flags_reg;
    assign key_out   = key_reg;
    assign id_out    = id_reg;

endmodule

`default_nettype wire

/* rtl/vertex_index_dedup_top.sv */
// Top level of the vertex index deduplication table: input stage, cell chain, result register.
`default_nettype none

// Each request (a position, normal and texture index triple) walks a chain of
// TABLE_DEPTH cells, one cell per cycle while the result register is not
// stalled, and leaves through a result register. The first cell captures the
// request at the accepting edge; the request is then registered in each cell in
// turn and last in the result register. While the result register is not
// stalled, requests follow each other in every cycle: the sustained rate is one
// request per cycle. Each cell holds one table entry; a request compares itself
// with every entry it passes and is inserted into the first empty cell it meets
// if it found no match, so a later request always sees the insertions of the
// ones ahead of it. Ids are handed out in insertion order; an unseen triple
// arriving at a full table comes out with overflow set and vertex_id zero. Only
// the low INDEX_BITS bits of each index are kept. The table is empty after reset;
// there is no clearing pass. A stalled result register holds the whole chain.
module vertex_index_dedup_top
    import vid_pkg::*;
#(
    parameter int unsigned TABLE_DEPTH = DEFAULT_TABLE_DEPTH,
    parameter int unsigned INDEX_BITS  = DEFAULT_INDEX_BITS
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [FIELD_W-1:0]     position_index,
    input  logic [FIELD_W-1:0]     normal_index,
    input  logic [FIELD_W-1:0]     texture_index,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [VERTEX_ID_W-1:0] vertex_id,
    output logic                   is_new,
    output logic                   overflow
);

    localparam int unsigned ID_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int unsigned KEY_W = 3 * INDEX_BITS;
    localparam int unsigned KEEP  = (INDEX_BITS < FIELD_W) ? INDEX_BITS : FIELD_W;

    vid_flags_t             chain_flags [TABLE_DEPTH+1];
    logic [KEY_W-1:0]       chain_key   [TABLE_DEPTH+1];
    logic [ID_W-1:0]        chain_id    [TABLE_DEPTH+1];
    logic                   advance;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic [VERTEX_ID_W-1:0] vertex_id_reg;
    logic [VERTEX_ID_W-1:0] vertex_id_next;
    logic                   is_new_reg;
    logic                   is_new_next;
    logic                   overflow_reg;
    logic                   overflow_next;
    vid_flags_t             tail_flags;

    // Move the whole chain whenever the result register can take a request
    assign advance  = !out_valid_reg || out_ready;
    assign in_ready = advance;

    // Feed the head of the chain with the trimmed key
    always_comb
    begin
        chain_flags[0].valid  = in_valid;
        chain_flags[0].found  = 1'b0;
        chain_flags[0].is_new = 1'b0;
        chain_key[0]          = {INDEX_BITS'(texture_index[KEEP-1:0]),
                                 INDEX_BITS'(normal_index[KEEP-1:0]),
                                 INDEX_BITS'(position_index[KEEP-1:0])};
        chain_id[0]           = '0;
    end

    // Row of table cells
    for (genvar i = 0; i < TABLE_DEPTH; i++)
    begin : g_cell
        vid_cell #(
            .INDEX_BITS (INDEX_BITS),
            .ID_W       (ID_W),
            .SLOT       (i)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .advance    (advance),
            .flags_in   (chain_flags[i]),
            .key_in     (chain_key[i]),
            .id_in      (chain_id[i]),
            .flags_out  (chain_flags[i+1]),
            .key_out    (chain_key[i+1]),
            .id_out     (chain_id[i+1])
        );
    end

    // Form the result at the chain tail
    always_comb
    begin
        tail_flags     = chain_flags[TABLE_DEPTH];
        out_valid_next = tail_flags.valid;
        vertex_id_next = tail_flags.found ? VERTEX_ID_W'(chain_id[TABLE_DEPTH]) : '0;
        is_new_next    = tail_flags.is_new;
        overflow_next  = !tail_flags.found;
    end

    // Hold the result until it is taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            vertex_id_reg <= vertex_id_next;
            is_new_reg    <= is_new_next;
            overflow_reg  <= overflow_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign vertex_id = vertex_id_reg;
    assign is_new    = is_new_reg;
    assign overflow  = overflow_reg;

endmodule

`default_nettype wire

/* rtl/vid_checker.sv */
// Port-level checks for the vertex index deduplication table, bound to the top level.
`default_nettype none

module vid_checker
    import vid_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_ready,
    input  logic                   out_valid,
    input  logic                   out_ready,
    input  logic [VERTEX_ID_W-1:0] vertex_id,
    input  logic                   is_new,
    input  logic                   overflow
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(vertex_id)
            && $stable(is_new) && $stable(overflow))
        else $error("stalled result changed");

    // A stalled result stops new requests from entering
    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("request accepted while result stalled");

    // An overflow result carries no insertion and a zero id
    a_overflow_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && overflow |-> !is_new && vertex_id == '0)
        else $error("overflow result malformed");

    // Two inserted results in a row never share an id
    a_new_ids_differ: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && is_new |=>
            !(out_valid && is_new && vertex_id == $past(vertex_id)))
        else $error("same id handed out twice in a row");

endmodule

bind vertex_index_dedup_top vid_checker u_vid_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .vertex_id (vertex_id),
    .is_new    (is_new),
    .overflow  (overflow)
);

`default_nettype wire
